/* hdl/ppu_pkg.sv */
`timescale 1ns / 1ps

package ppu_pkg;

    // Transaction kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Register numbers (bus address modulo 8)
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Highest address that still goes through the read buffer (below palette)
    localparam logic [15:0] BUFFERED_TOP = 16'h3EFF;
    localparam logic [15:0] STEP_ACROSS  = 16'd1;
    localparam logic [15:0] STEP_DOWN    = 16'd32;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] vram_data;
        logic [7:0] status_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        vram_write;
        logic        vram_read;
        logic [15:0] vram_addr;
        logic [7:0]  vram_wdata;
        logic [15:0] video_addr;
        logic [14:0] temp_addr;
        logic [2:0]  fine_scroll_x;
        logic [7:0]  ctrl_value;
        logic [7:0]  mask_value;
    } t_out_item;

endpackage

/* hdl/ppu_if.sv */
`timescale 1ns / 1ps

interface ppu_in_if;
    logic              valid;
    logic              ready;
    ppu_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface ppu_out_if;
    logic               valid;
    logic               ready;
    ppu_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* hdl/ppu_in_stage.sv */
`timescale 1ns / 1ps

module ppu_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ppu_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_advance,
    output logic              o_valid,
    output ppu_pkg::t_in_item o_item
);

    logic              r_valid;
    ppu_pkg::t_in_item r_item;
    logic              w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/ppu_regfile.sv */
`timescale 1ns / 1ps

module ppu_regfile (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  ppu_pkg::t_in_item  i_item,
    output ppu_pkg::t_out_item o_result
);

    logic [7:0]  r_ctrl,   n_ctrl;
    logic [7:0]  r_mask,   n_mask;
    logic [7:0]  r_status, n_status;
    logic [14:0] r_temp,   n_temp;
    logic [15:0] r_video,  n_video;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_latch,  n_latch;

    logic [15:0] w_step;
    logic [7:0]  w_d;

    assign w_step = r_ctrl[2] ? ppu_pkg::STEP_DOWN : ppu_pkg::STEP_ACROSS;
    assign w_d    = i_item.write_data;

    always_comb begin
        n_ctrl   = r_ctrl;
        n_mask   = r_mask;
        n_status = r_status;
        n_temp   = r_temp;
        n_video  = r_video;
        n_fine_x = r_fine_x;
        n_toggle = r_toggle;
        n_latch  = r_latch;

        o_result            = '0;

        case (i_item.kind)
            ppu_pkg::KIND_WRITE: begin
                case (i_item.reg_index)
                    ppu_pkg::REG_CTRL: begin
                        n_ctrl         = w_d;
                        n_temp[11:10]  = w_d[1:0];
                    end
                    ppu_pkg::REG_MASK: begin
                        n_mask = w_d;
                    end
                    ppu_pkg::REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_temp[4:0] = w_d[7:3];
                            n_fine_x    = w_d[2:0];
                        end else begin
                            n_temp[9:5]   = w_d[7:3];
                            n_temp[14:12] = w_d[2:0];
                        end
                        n_toggle = !r_toggle;
                    end
                    ppu_pkg::REG_ADDR: begin
                        if (!r_toggle) begin
                            n_temp[13:8] = w_d[5:0];
                            n_temp[14]   = 1'b0;
                        end else begin
                            n_temp[7:0] = w_d;
                            n_video     = {1'b0, r_temp[14:8], w_d};
                        end
                        n_toggle = !r_toggle;
                    end
                    ppu_pkg::REG_DATA: begin
                        o_result.vram_write = 1'b1;
                        o_result.vram_addr  = r_video;
                        o_result.vram_wdata = w_d;
                        n_video             = r_video + w_step;
                    end
                    default: ;
                endcase
            end
            ppu_pkg::KIND_READ: begin
                case (i_item.reg_index)
                    ppu_pkg::REG_STATUS: begin
                        o_result.read_data = r_status;
                        n_status[7]        = 1'b0;
                        n_toggle           = 1'b0;
                    end
                    ppu_pkg::REG_DATA: begin
                        o_result.vram_read = 1'b1;
                        o_result.vram_addr = r_video;
                        n_latch            = i_item.vram_data;
                        // below the palette the CPU sees the previous buffer
                        o_result.read_data = (r_video <= ppu_pkg::BUFFERED_TOP)
                                             ? r_latch : i_item.vram_data;
                        n_video            = r_video + w_step;
                    end
                    default: ;
                endcase
            end
            ppu_pkg::KIND_STATUS: begin
                n_status = i_item.status_value;
            end
            default: ;
        endcase

        o_result.video_addr    = n_video;
        o_result.temp_addr     = n_temp;
        o_result.fine_scroll_x = n_fine_x;
        o_result.ctrl_value    = n_ctrl;
        o_result.mask_value    = n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_mask   <= '0;
            r_status <= '0;
            r_temp   <= '0;
            r_video  <= '0;
            r_fine_x <= '0;
            r_toggle <= 1'b0;
            r_latch  <= '0;
        end else if (i_advance) begin
            r_ctrl   <= n_ctrl;
            r_mask   <= n_mask;
            r_status <= n_status;
            r_temp   <= n_temp;
            r_video  <= n_video;
            r_fine_x <= n_fine_x;
            r_toggle <= n_toggle;
            r_latch  <= n_latch;
        end
    end

endmodule

/* hdl/ppu_out_stage.sv */
`timescale 1ns / 1ps

module ppu_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ppu_pkg::t_out_item i_item,
    output logic               o_load_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output ppu_pkg::t_out_item o_item
);

    logic               r_valid;
    ppu_pkg::t_out_item r_item;
    logic               w_load;

    assign o_load_ready = !r_valid || i_ready;
    assign w_load       = i_valid && o_load_ready;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/ppu_register_port.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload               Transaction
// i_in      in   ppu_pkg::t_in_item    one CPU access or renderer status load
// o_out     out  ppu_pkg::t_out_item   access result plus register snapshot
//
// Result path: the input register feeds the register-file update logic, which
// loads the result register. One transaction per cycle sustained while o_out
// is ready; the register file is the only state carried between transactions
// and it updates as a transaction moves on.
// Synchronous active-low reset clears the register file and both valid flags.
// A stalled output holds its result; the input register keeps one more
// transaction, after which i_in.ready drops until o_out drains.

module ppu_register_port (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ppu_in_if.sink           i_in,
    ppu_out_if.source        o_out
);

    logic               w_stage_valid;
    ppu_pkg::t_in_item  w_stage_item;
    logic               w_out_ready;
    logic               w_advance;
    ppu_pkg::t_out_item w_result;

    // A transaction leaves the input register (and commits its state update)
    // only when the result register can take its result.
    assign w_advance = w_stage_valid && w_out_ready;

    ppu_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (i_in.item),
        .o_ready   (i_in.ready),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    // Scroll/address toggle, read buffer and control bytes live here.
    ppu_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_stage_item),
        .o_result  (w_result)
    );

    ppu_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_stage_valid),
        .i_item       (w_result),
        .o_load_ready (w_out_ready),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_item       (o_out.item)
    );

endmodule

/* hdl/ppu_register_port_checker.sv */
`timescale 1ns / 1ps

module ppu_register_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ppu_pkg::t_out_item i_out_item
);

    // Stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_item.vram_write && i_out_item.vram_read))
        else $error("video memory read and write in one transaction");

    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.vram_write |-> i_out_item.vram_wdata == 8'd0)
        else $error("write data without a write");

    a_addr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.vram_write && !i_out_item.vram_read
        |-> i_out_item.vram_addr == 16'd0)
        else $error("video address without an access");

endmodule

bind ppu_register_port ppu_register_port_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);

/* sim/ppu_register_port_tb.sv */
`timescale 1ns / 1ps

module ppu_register_port_tb;

    // Kind code the block does not define; it must leave all state alone
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int PHASE_ITEMS = 50;
    localparam int SWEEP_ITEMS = 1026;  // 0x7FE0 stepping by 32 passes 0xFFFF
    localparam int HOLD_AT     = 600;   // result count that starts the long stall
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        ppu_pkg::t_in_item  it;
        bit                 typed;
        ppu_pkg::t_out_item want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    ppu_in_if  in_ch();
    ppu_out_if out_ch();

    ppu_register_port u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Shadow register file
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  status_q;
    logic [14:0] t_addr;
    logic [15:0] v_addr;
    logic [2:0]  fine_q;
    logic        wr_phase;
    logic [7:0]  read_buf;

    ppu_pkg::t_out_item pending[$];
    t_script_row        script[$];
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 items_sent;
    int                 results_seen;
    int                 mismatches;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    function automatic void reset_shadow();
        ctrl_q   = '0;
        mask_q   = '0;
        status_q = '0;
        t_addr   = '0;
        v_addr   = '0;
        fine_q   = '0;
        wr_phase = 1'b0;
        read_buf = '0;
    endfunction

    // One bus access against the shadow state; returns the result snapshot
    function automatic ppu_pkg::t_out_item apply_access(ppu_pkg::t_in_item it);
        ppu_pkg::t_out_item r;
        logic [7:0]         d;
        logic [15:0]        stride;
        r      = '0;
        d      = it.write_data;
        stride = ctrl_q[2] ? ppu_pkg::STEP_DOWN : ppu_pkg::STEP_ACROSS;
        case (it.kind)
            ppu_pkg::KIND_WRITE: begin
                case (it.reg_index)
                    ppu_pkg::REG_CTRL: begin
                        ctrl_q        = d;
                        t_addr[11:10] = d[1:0];
                    end
                    ppu_pkg::REG_MASK: mask_q = d;
                    ppu_pkg::REG_SCROLL: begin
                        if (!wr_phase) begin
                            t_addr[4:0] = d[7:3];
                            fine_q      = d[2:0];
                        end else begin
                            t_addr[9:5]   = d[7:3];
                            t_addr[14:12] = d[2:0];
                        end
                        wr_phase = ~wr_phase;
                    end
                    ppu_pkg::REG_ADDR: begin
                        if (!wr_phase) begin
                            t_addr[13:8] = d[5:0];
                            t_addr[14]   = 1'b0;
                        end else begin
                            t_addr[7:0] = d;
                            v_addr      = {1'b0, t_addr};
                        end
                        wr_phase = ~wr_phase;
                    end
                    ppu_pkg::REG_DATA: begin
                        r.vram_write = 1'b1;
                        r.vram_addr  = v_addr;
                        r.vram_wdata = d;
                        v_addr       = v_addr + stride;
                    end
                    default: ;
                endcase
            end
            ppu_pkg::KIND_READ: begin
                if (it.reg_index == ppu_pkg::REG_STATUS) begin
                    r.read_data = status_q;
                    status_q[7] = 1'b0;
                    wr_phase    = 1'b0;
                end else if (it.reg_index == ppu_pkg::REG_DATA) begin
                    // buffered below palette space, direct above it
                    r.vram_read = 1'b1;
                    r.vram_addr = v_addr;
                    r.read_data = (v_addr <= ppu_pkg::BUFFERED_TOP) ? read_buf
                                                                    : it.vram_data;
                    read_buf    = it.vram_data;
                    v_addr      = v_addr + stride;
                end
            end
            ppu_pkg::KIND_STATUS: status_q = it.status_value;
            default: ;
        endcase
        r.video_addr    = v_addr;
        r.temp_addr     = t_addr;
        r.fine_scroll_x = fine_q;
        r.ctrl_value    = ctrl_q;
        r.mask_value    = mask_q;
        return r;
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Access with random filler in the fields it does not use
    function automatic ppu_pkg::t_in_item mk(logic [1:0] k, logic [2:0] r, logic [7:0] d);
        ppu_pkg::t_in_item it;
        it.kind         = k;
        it.reg_index    = r;
        it.write_data   = d;
        it.vram_data    = rnd8();
        it.status_value = rnd8();
        return it;
    endfunction

    task automatic add_row(input logic [1:0] k, input logic [2:0] r, input logic [7:0] d,
                           input logic [7:0] vd, input logic [7:0] sv, input bit typed,
                           input ppu_pkg::t_out_item want);
        t_script_row row;
        row.it    = '{kind: k, reg_index: r, write_data: d, vram_data: vd, status_value: sv};
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    // Called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input ppu_pkg::t_in_item it, input bit typed = 1'b0,
                             input ppu_pkg::t_out_item want = '0);
        ppu_pkg::t_out_item predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = apply_access(it);
        pending.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending.size() != 0);
    endtask

    task automatic random_scenario();
        int n;
        logic [7:0] hi;
        case ($urandom_range(0, 9))
            0: begin
                // clean address load
                send_item(mk(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, rnd8()));
                send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, rnd8()));
                send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, rnd8()));
            end
            1: begin
                send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_SCROLL, rnd8()));
                send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_SCROLL, rnd8()));
            end
            2: begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_item(mk($urandom_range(0, 1) ? ppu_pkg::KIND_WRITE
                                                      : ppu_pkg::KIND_READ,
                                 ppu_pkg::REG_DATA, rnd8()));
            end
            3: send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_CTRL, rnd8()));
            4: send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_MASK, rnd8()));
            5: send_item(mk(ppu_pkg::KIND_STATUS, 3'($urandom_range(0, 7)), rnd8()));
            6, 7: send_item(mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rnd8()));
            8: begin
                // land near the buffered/palette boundary and read across it
                hi = {rnd8() & 8'hC1} | 8'h3E;
                send_item(mk(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, rnd8()));
                send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, hi));
                send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, rnd8()));
                n = $urandom_range(1, 4);
                repeat (n) send_item(mk(ppu_pkg::KIND_READ, ppu_pkg::REG_DATA, rnd8()));
            end
            default: send_item(mk(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, rnd8()));
        endcase
    endtask

    task automatic random_phase();
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) random_scenario();
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Result side: compare every accepted transaction with the oldest prediction
    always @(posedge i_clk) begin
        ppu_pkg::t_out_item want;
        ppu_pkg::t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.item;
            results_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                mismatches++;
            end else begin
                want = pending.pop_front();
                check_field("read_data",     16'(want.read_data),     16'(got.read_data));
                check_field("vram_write",    16'(want.vram_write),    16'(got.vram_write));
                check_field("vram_read",     16'(want.vram_read),     16'(got.vram_read));
                check_field("vram_addr",     want.vram_addr,          got.vram_addr);
                check_field("vram_wdata",    16'(want.vram_wdata),    16'(got.vram_wdata));
                check_field("video_addr",    want.video_addr,         got.video_addr);
                check_field("temp_addr",     16'(want.temp_addr),     16'(got.temp_addr));
                check_field("fine_scroll_x", 16'(want.fine_scroll_x), 16'(got.fine_scroll_x));
                check_field("ctrl_value",    16'(want.ctrl_value),    16'(got.ctrl_value));
                check_field("mask_value",    16'(want.mask_value),    16'(got.mask_value));
            end
        end
    end

    // Receiver: random back-pressure plus one long stall to fill the block
    initial begin
        int  hold_left;
        bit  held;
        hold_left    = 0;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.item    = '0;
        i_rst_n       = 1'b0;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        src_idle_pct  = 34;
        sink_idle_pct = 62;
        reset_shadow();

        // Expected snapshot field order: read_data, vram_write, vram_read, vram_addr,
        // vram_wdata, video_addr, temp_addr, fine_scroll_x, ctrl_value, mask_value
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, 8'h00, 8'h00, 8'h00, 1'b1, '0);
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_CTRL, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_CTRL, 8'hFF, 8'h00, 8'h00, 1'b1,
                {8'h00, 1'b0, 1'b0, 16'h0, 8'h00, 16'h0, 15'h0C00, 3'd0, 8'hFF, 8'h00});
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_MASK, 8'hFF, 8'h00, 8'h00, 1'b1,
                {8'h00, 1'b0, 1'b0, 16'h0, 8'h00, 16'h0, 15'h0C00, 3'd0, 8'hFF, 8'hFF});
        add_row(ppu_pkg::KIND_STATUS, ppu_pkg::REG_CTRL, 8'h00, 8'h00, 8'hFF, 1'b1,
                {8'h00, 1'b0, 1'b0, 16'h0, 8'h00, 16'h0, 15'h0C00, 3'd0, 8'hFF, 8'hFF});
        // status read returns the byte then drops bit 7
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, 8'h00, 8'h00, 8'h00, 1'b1,
                {8'hFF, 1'b0, 1'b0, 16'h0, 8'h00, 16'h0, 15'h0C00, 3'd0, 8'hFF, 8'hFF});
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, 8'h00, 8'h00, 8'h00, 1'b1,
                {8'h7F, 1'b0, 1'b0, 16'h0, 8'h00, 16'h0, 15'h0C00, 3'd0, 8'hFF, 8'hFF});
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_SCROLL, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_SCROLL, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, 8'h3F, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        // palette, step 32
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_DATA, 8'h00, 8'hA5, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_CTRL, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, 8'h3E, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        // last buffered address, then first palette address
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_DATA, 8'h00, 8'h5A, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_DATA, 8'h00, 8'hC3, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_DATA, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_OAM_ADDR, 8'h12, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_OAM_DATA, 8'h34, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_OAM_DATA, 8'h00, 8'h77, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_WRITE, ppu_pkg::REG_STATUS, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_SCROLL, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(ppu_pkg::KIND_READ, ppu_pkg::REG_ADDR, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_row(KIND_UNUSED, ppu_pkg::REG_DATA, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send_item(script[i].it, script[i].typed, script[i].want);
        wait_drained();

        random_phase();
        wait_drained();

        src_idle_pct  = 62;
        sink_idle_pct = 34;
        random_phase();
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // Video address wrap: build 0x7FE0 through the shared toggle, then step by 32
        // past 0xFFFF
        send_item(mk(ppu_pkg::KIND_READ, ppu_pkg::REG_STATUS, rnd8()));
        send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_CTRL, (rnd8() & 8'hFB) | 8'h04));
        send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, (rnd8() & 8'hC0) | 8'h3F));
        send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_SCROLL, rnd8() | 8'hC7));
        send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_SCROLL, rnd8()));
        send_item(mk(ppu_pkg::KIND_WRITE, ppu_pkg::REG_ADDR, 8'hE0));
        repeat (SWEEP_ITEMS)
            send_item(mk($urandom_range(0, 1) ? ppu_pkg::KIND_WRITE : ppu_pkg::KIND_READ,
                         ppu_pkg::REG_DATA, rnd8()));

        in_ch.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
